// ----- rtl/trs_mc_pkg.sv -----
// Shared types, constants and fixed-point helpers for the TRS matrix compose block.
package trs_mc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int DPROD_W    = PROD_W + 1;
	localparam int SUM_W      = DATA_WIDTH + 2;
	localparam int TRUNC_W    = DPROD_W - FRAC_BITS;
	localparam int NUM_PROD   = 9;
	localparam int NUM_AXES   = 3;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [DPROD_W-1:0]    dprod_t;
	typedef logic signed [SUM_W-1:0]      sum_t;

	typedef data_t prodvec_t [NUM_PROD];
	typedef data_t rotvec_t  [NUM_PROD];
	typedef data_t axisvec_t [NUM_AXES];

	// Slots of the doubled quaternion products
	localparam int P_XX = 0;
	localparam int P_YY = 1;
	localparam int P_ZZ = 2;
	localparam int P_XY = 3;
	localparam int P_XZ = 4;
	localparam int P_YZ = 5;
	localparam int P_WX = 6;
	localparam int P_WY = 7;
	localparam int P_WZ = 8;

	localparam sum_t Q_ONE = sum_t'(1) <<< FRAC_BITS;

	// Shift right by FRAC_BITS toward zero, then clamp to the data range.
	function automatic data_t trunc_sat(input dprod_t d);
		logic signed [TRUNC_W-1:0] t;
		logic                      rnd;
		logic                      ovf;
		rnd = d[DPROD_W-1] && (d[FRAC_BITS-1:0] != '0);
		t = d[DPROD_W-1:FRAC_BITS];
		t = t + {{(TRUNC_W-1){1'b0}}, rnd};
		ovf = (t[TRUNC_W-1:DATA_WIDTH-1] != '0) && (t[TRUNC_W-1:DATA_WIDTH-1] != '1);
		if (ovf) begin
			return {t[TRUNC_W-1], {(DATA_WIDTH-1){~t[TRUNC_W-1]}}};
		end
		return t[DATA_WIDTH-1:0];
	endfunction

	function automatic data_t sum_sat(input sum_t s);
		logic ovf;
		ovf = (s[SUM_W-1:DATA_WIDTH-1] != '0) && (s[SUM_W-1:DATA_WIDTH-1] != '1);
		if (ovf) begin
			return {s[SUM_W-1], {(DATA_WIDTH-1){~s[SUM_W-1]}}};
		end
		return s[DATA_WIDTH-1:0];
	endfunction

endpackage

// ----- rtl/trs_mc_if.sv -----
// Handshake channels: transform components in, affine matrix rows out.
interface trs_mc_xform_if;
	import trs_mc_pkg::*;

	logic  valid;
	logic  ready;
	data_t quat_x;
	data_t quat_y;
	data_t quat_z;
	data_t quat_w;
	data_t scale_x;
	data_t scale_y;
	data_t scale_z;
	data_t position_x;
	data_t position_y;
	data_t position_z;

	modport source (
		output valid, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z,
		       position_x, position_y, position_z,
		input  ready
	);
	modport sink (
		input  valid, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z,
		       position_x, position_y, position_z,
		output ready
	);
endinterface

interface trs_mc_matrix_if;
	import trs_mc_pkg::*;

	logic  valid;
	logic  ready;
	data_t elem_r1c1;
	data_t elem_r1c2;
	data_t elem_r1c3;
	data_t elem_r2c1;
	data_t elem_r2c2;
	data_t elem_r2c3;
	data_t elem_r3c1;
	data_t elem_r3c2;
	data_t elem_r3c3;
	data_t trans_out_x;
	data_t trans_out_y;
	data_t trans_out_z;

	modport source (
		output valid, elem_r1c1, elem_r1c2, elem_r1c3, elem_r2c1, elem_r2c2, elem_r2c3,
		       elem_r3c1, elem_r3c2, elem_r3c3, trans_out_x, trans_out_y, trans_out_z,
		input  ready
	);
	modport sink (
		input  valid, elem_r1c1, elem_r1c2, elem_r1c3, elem_r2c1, elem_r2c2, elem_r2c3,
		       elem_r3c1, elem_r3c2, elem_r3c3, trans_out_x, trans_out_y, trans_out_z,
		output ready
	);
endinterface

// ----- rtl/trs_matrix_compose_core.sv -----
// Top level: five-stage pipeline from quaternion, scale and translation to affine matrix.
// The output register is stage 5; matrix.valid is the stage 5 valid bit.
// Throughput: one beat per cycle unless matrix.ready stalls; each stage holds one item and moves when the next is free.
// Stages: 32x32 products, truncate+saturate, rotation sums, scale multiply, final truncate.
// Reset: arst_n clears all stage valid bits; data registers are not reset.
module trs_matrix_compose_core (
	input  logic            clk,
	input  logic            arst_n,
	trs_mc_xform_if.sink    xform,
	trs_mc_matrix_if.source matrix
);
	import trs_mc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	prod_t    p_s1 [NUM_PROD];
	axisvec_t scale_s1, scale_s2, scale_s3;
	axisvec_t pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	prodvec_t dbl_s2;
	rotvec_t  rot_s3;
	rotvec_t  rot_next;
	prod_t    m_s4 [NUM_PROD];
	rotvec_t  elem_s5;

	// per-stage ready: a stage can load when empty or when its contents move on
	assign rdy5 = !v_s5 || matrix.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign xform.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= xform.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: raw quaternion products; doubling is a shift taken in stage 2
	always_ff @(posedge clk) begin
		if (rdy1 && xform.valid) begin
			p_s1[P_XX] <= xform.quat_x * xform.quat_x;
			p_s1[P_YY] <= xform.quat_y * xform.quat_y;
			p_s1[P_ZZ] <= xform.quat_z * xform.quat_z;
			p_s1[P_XY] <= xform.quat_x * xform.quat_y;
			p_s1[P_XZ] <= xform.quat_x * xform.quat_z;
			p_s1[P_YZ] <= xform.quat_y * xform.quat_z;
			p_s1[P_WX] <= xform.quat_w * xform.quat_x;
			p_s1[P_WY] <= xform.quat_w * xform.quat_y;
			p_s1[P_WZ] <= xform.quat_w * xform.quat_z;
			scale_s1[0] <= xform.scale_x;
			scale_s1[1] <= xform.scale_y;
			scale_s1[2] <= xform.scale_z;
			pos_s1[0]   <= xform.position_x;
			pos_s1[1]   <= xform.position_y;
			pos_s1[2]   <= xform.position_z;
		end
	end

	// stage 2: doubled product, truncated toward zero and saturated
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int k = 0; k < NUM_PROD; k++) begin
				dbl_s2[k] <= trunc_sat({p_s1[k], 1'b0});
			end
			scale_s2 <= scale_s1;
			pos_s2   <= pos_s1;
		end
	end

	trs_mc_rotsum u_rotsum (
		.prod (dbl_s2),
		.rot  (rot_next)
	);

	// stage 3: saturated rotation entries
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			rot_s3   <= rot_next;
			scale_s3 <= scale_s2;
			pos_s3   <= pos_s2;
		end
	end

	// stage 4: row r scaled by the r-th scale
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				for (int c = 0; c < NUM_AXES; c++) begin
					m_s4[r*NUM_AXES + c] <= rot_s3[r*NUM_AXES + c] * scale_s3[r];
				end
			end
			pos_s4 <= pos_s3;
		end
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			for (int k = 0; k < NUM_PROD; k++) begin
				elem_s5[k] <= trunc_sat({m_s4[k][PROD_W-1], m_s4[k]});
			end
			pos_s5 <= pos_s4;
		end
	end

	assign matrix.valid       = v_s5;
	assign matrix.elem_r1c1   = elem_s5[0];
	assign matrix.elem_r1c2   = elem_s5[1];
	assign matrix.elem_r1c3   = elem_s5[2];
	assign matrix.elem_r2c1   = elem_s5[3];
	assign matrix.elem_r2c2   = elem_s5[4];
	assign matrix.elem_r2c3   = elem_s5[5];
	assign matrix.elem_r3c1   = elem_s5[6];
	assign matrix.elem_r3c2   = elem_s5[7];
	assign matrix.elem_r3c3   = elem_s5[8];
	assign matrix.trans_out_x = pos_s5[0];
	assign matrix.trans_out_y = pos_s5[1];
	assign matrix.trans_out_z = pos_s5[2];
endmodule

// ----- rtl/trs_mc_rotsum.sv -----
// Rotation matrix entries from the saturated doubled quaternion products.
module trs_mc_rotsum (
	input  trs_mc_pkg::prodvec_t prod,
	output trs_mc_pkg::rotvec_t  rot
);
	import trs_mc_pkg::*;

	sum_t xx, yy, zz, xy, xz, yz, wx, wy, wz;

	always_comb begin
		xx = sum_t'(prod[P_XX]);
		yy = sum_t'(prod[P_YY]);
		zz = sum_t'(prod[P_ZZ]);
		xy = sum_t'(prod[P_XY]);
		xz = sum_t'(prod[P_XZ]);
		yz = sum_t'(prod[P_YZ]);
		wx = sum_t'(prod[P_WX]);
		wy = sum_t'(prod[P_WY]);
		wz = sum_t'(prod[P_WZ]);

		rot[0] = sum_sat(Q_ONE - yy - zz);
		rot[1] = sum_sat(xy + wz);
		rot[2] = sum_sat(xz - wy);
		rot[3] = sum_sat(xy - wz);
		rot[4] = sum_sat(Q_ONE - xx - zz);
		rot[5] = sum_sat(yz + wx);
		rot[6] = sum_sat(xz + wy);
		rot[7] = sum_sat(yz - wx);
		rot[8] = sum_sat(Q_ONE - xx - yy);
	end
endmodule
